// ----- hdl/tiltrotor_gravity_vector_top_defines.svh -----
// ----------------------------------------------------------------------------
// Tilt-rotor gravity vector: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TILTROTOR_GRAVITY_VECTOR_TOP_DEFINES_SVH
`define TILTROTOR_GRAVITY_VECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define TGV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TGV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tgv_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt-rotor gravity vector: package
// Widths, CORDIC constants, register indexes, rounding and saturating helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgv_pkg;

   localparam int ANGLE_W      = 15;
   localparam int REG_W        = 32;
   localparam int TILT_W       = 16;
   localparam int RES_W        = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int XW           = 34;
   localparam int ZW           = 35;
   localparam int QW           = 24;
   localparam int TW           = 40;
   localparam int SW           = 44;

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(64'sh26DD3B6A);
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
   localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);

   localparam logic signed [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
      32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
      32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
      32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
      32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RIGHT_ARM_WEIGHT = 3'd0,
      CSR_LEFT_ARM_WEIGHT  = 3'd1,
      CSR_TILT_SINE        = 3'd2,
      CSR_TILT_COSINE      = 3'd3,
      CSR_MOMENT_X         = 3'd4,
      CSR_MOMENT_Y         = 3'd5,
      CSR_MOMENT_Z         = 3'd6,
      CSR_TOTAL_WEIGHT     = 3'd7
   } csr_index_type;

   // product of two signed words, rounded half up to Q16
   function automatic logic signed [63:0] mrnd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return (p + 64'sd32768) >>> 16;
   endfunction

   function automatic logic [RES_W-1:0] sat32(input logic signed [SW-1:0] v);
      logic [RES_W-1:0] r;
      if (v > SW'(64'sd2147483647)) begin
         r = 32'h7FFF_FFFF;
      end else if (v < SW'(-64'sd2147483648)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[RES_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- hdl/tgv_cordic.sv -----
// ----------------------------------------------------------------------------
// Tilt-rotor gravity vector: CORDIC lane
// Quadrant fold, one register stage per rotation, rounding to Q16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgv_cordic
   import tgv_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS
) (
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [ANGLE_W-1:0] angle,
   output logic signed [QW-1:0]      sin_q16,
   output logic signed [QW-1:0]      cos_q16
);

   localparam int NS = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

   logic signed [XW-1:0] x_ff [NS+1];
   logic signed [XW-1:0] y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic                 flip_ff [NS+1];
   logic signed [ZW-1:0] z_in;
   logic                 flip_in;
   logic signed [XW-1:0] xf_in;
   logic signed [XW-1:0] xr_in;
   logic signed [XW-1:0] yr_in;
   logic signed [QW-1:0] sin_ff;
   logic signed [QW-1:0] cos_ff;

   always_comb begin
      z_in    = ZW'(angle) <<< 18;
      flip_in = 1'b0;
      if (z_in > HALF_PI_Q30) begin
         z_in    = PI_Q30 - z_in;
         flip_in = 1'b1;
      end else if (z_in < -HALF_PI_Q30) begin
         z_in    = -PI_Q30 - z_in;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ZW'(ATAN_Q30[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ZW'(ATAN_Q30[i]);
            end
         end
      end
   end

   always_comb begin
      xf_in = flip_ff[NS] ? -x_ff[NS] : x_ff[NS];
      xr_in = (xf_in + XW'(8192)) >>> 14;
      yr_in = (y_ff[NS] + XW'(8192)) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= QW'(yr_in);
         cos_ff <= QW'(xr_in);
      end
   end

   assign sin_q16 = sin_ff;
   assign cos_q16 = cos_ff;

endmodule

// ----- hdl/tgv_gravity.sv -----
// ----------------------------------------------------------------------------
// Tilt-rotor gravity vector: torque datapath
// Four multiply stages and a saturating sum stage over the trig terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgv_gravity
   import tgv_pkg::*;
(
   input  logic                     clock,
   input  logic                     adv,
   input  logic signed [QW-1:0]     s_ar,
   input  logic signed [QW-1:0]     c_ar,
   input  logic signed [QW-1:0]     s_al,
   input  logic signed [QW-1:0]     c_al,
   input  logic signed [QW-1:0]     s_p,
   input  logic signed [QW-1:0]     c_p,
   input  logic signed [QW-1:0]     s_t,
   input  logic signed [QW-1:0]     c_t,
   input  logic signed [REG_W-1:0]  k2,
   input  logic signed [REG_W-1:0]  k3,
   input  logic signed [TILT_W-1:0] tilt_sine,
   input  logic signed [TILT_W-1:0] tilt_cosine,
   input  logic signed [REG_W-1:0]  moment_x,
   input  logic signed [REG_W-1:0]  moment_y,
   input  logic signed [REG_W-1:0]  moment_z,
   input  logic signed [REG_W-1:0]  total_weight,
   output logic [RES_W-1:0]         right_joint_torque,
   output logic [RES_W-1:0]         left_joint_torque,
   output logic [RES_W-1:0]         roll_torque,
   output logic [RES_W-1:0]         pitch_torque,
   output logic [RES_W-1:0]         vertical_force
);

   logic signed [QW-1:0] sb;
   logic signed [QW-1:0] cb;

   // stage 1
   logic signed [QW-1:0] pc_ff, ps_ff, cs_ff, ss_ff, t1r_ff, t1l_ff, ur_ff, ul_ff;
   logic signed [QW-1:0] sarc_ff, salc_ff, car1_ff, cal1_ff, ct1_ff;
   // stage 2
   logic signed [QW-1:0] ur2_ff, ul2_ff, a2_ff, arp_ff, alp_ff, bss2_ff;
   logic signed [QW-1:0] csr2_ff, csl2_ff, acr_ff, acl_ff, t1r2_ff, t1l2_ff;
   logic signed [TW-1:0] mypc_ff, mzps_ff, mxct_ff, mzcs_ff, myss_ff;
   // stage 3
   logic signed [QW-1:0] fr_ff, fl_ff, br_ff, bl_ff, cbr_ff, cbl_ff;
   logic signed [QW-1:0] a3_ff, bss3_ff, csr3_ff, csl3_ff;
   logic signed [SW-1:0] m2_ff, m3_ff;
   // stage 4
   logic signed [QW-1:0] pl_in, pr_in;
   logic signed [TW-1:0] r0_ff, r1_ff, r2a_ff, r2b_ff, r3a_ff, r3b_ff;
   logic signed [SW-1:0] m2b_ff, m3b_ff;
   // stage 5
   logic [RES_W-1:0] o0_ff, o1_ff, o2_ff, o3_ff, o4_ff;

   assign sb = QW'(tilt_sine) <<< 2;
   assign cb = QW'(tilt_cosine) <<< 2;

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff   <= QW'(mrnd(32'(c_p), 32'(c_t)));
         ps_ff   <= QW'(mrnd(32'(s_p), 32'(c_t)));
         cs_ff   <= QW'(mrnd(32'(c_p), 32'(s_t)));
         ss_ff   <= QW'(mrnd(32'(s_p), 32'(s_t)));
         t1r_ff  <= QW'(mrnd(32'(c_ar), 32'(s_t)));
         t1l_ff  <= QW'(mrnd(32'(c_al), 32'(s_t)));
         ur_ff   <= QW'(mrnd(32'(c_p), 32'(s_ar)));
         ul_ff   <= QW'(mrnd(32'(c_p), 32'(s_al)));
         sarc_ff <= QW'(mrnd(32'(s_ar), 32'(c_t)));
         salc_ff <= QW'(mrnd(32'(s_al), 32'(c_t)));
         car1_ff <= c_ar;
         cal1_ff <= c_al;
         ct1_ff  <= c_t;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ur2_ff  <= QW'(mrnd(32'(ur_ff), 32'(ct1_ff)));
         ul2_ff  <= QW'(mrnd(32'(ul_ff), 32'(ct1_ff)));
         a2_ff   <= QW'(mrnd(32'(sb), 32'(pc_ff)));
         arp_ff  <= QW'(mrnd(32'(car1_ff), 32'(ps_ff)));
         alp_ff  <= QW'(mrnd(32'(cal1_ff), 32'(ps_ff)));
         bss2_ff <= QW'(mrnd(32'(sb), 32'(ss_ff)));
         csr2_ff <= QW'(mrnd(32'(cb), 32'(sarc_ff)));
         csl2_ff <= QW'(mrnd(32'(cb), 32'(salc_ff)));
         acr_ff  <= QW'(mrnd(32'(car1_ff), 32'(cs_ff)));
         acl_ff  <= QW'(mrnd(32'(cal1_ff), 32'(cs_ff)));
         t1r2_ff <= t1r_ff;
         t1l2_ff <= t1l_ff;
         mypc_ff <= TW'(mrnd(moment_y, 32'(pc_ff)));
         mzps_ff <= TW'(mrnd(moment_z, 32'(ps_ff)));
         mxct_ff <= TW'(mrnd(moment_x, 32'(ct1_ff)));
         mzcs_ff <= TW'(mrnd(moment_z, 32'(cs_ff)));
         myss_ff <= TW'(mrnd(moment_y, 32'(ss_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff   <= QW'(mrnd(32'(cb), 32'(t1r2_ff) + 32'(ur2_ff)));
         fl_ff   <= QW'(mrnd(32'(cb), 32'(t1l2_ff) + 32'(ul2_ff)));
         br_ff   <= QW'(mrnd(32'(cb), 32'(arp_ff)));
         bl_ff   <= QW'(mrnd(32'(cb), 32'(alp_ff)));
         cbr_ff  <= QW'(mrnd(32'(cb), 32'(acr_ff)));
         cbl_ff  <= QW'(mrnd(32'(cb), 32'(acl_ff)));
         a3_ff   <= a2_ff;
         bss3_ff <= bss2_ff;
         csr3_ff <= csr2_ff;
         csl3_ff <= csl2_ff;
         m2_ff   <= SW'(mypc_ff) - SW'(mzps_ff);
         m3_ff   <= -(SW'(mxct_ff) + SW'(mzcs_ff) + SW'(myss_ff));
      end
   end

   assign pl_in = csl3_ff - bss3_ff + cbl_ff;
   assign pr_in = csr3_ff + bss3_ff + cbr_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff  <= TW'(mrnd(k2, 32'(fr_ff)));
         r1_ff  <= TW'(mrnd(k3, 32'(fl_ff)));
         r2a_ff <= TW'(mrnd(k2, 32'(a3_ff) - 32'(br_ff)));
         r2b_ff <= TW'(mrnd(k3, 32'(a3_ff) + 32'(bl_ff)));
         r3a_ff <= TW'(mrnd(k3, 32'(pl_in)));
         r3b_ff <= TW'(mrnd(k2, 32'(pr_in)));
         m2b_ff <= m2_ff;
         m3b_ff <= m3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o0_ff <= sat32(-SW'(r0_ff));
         o1_ff <= sat32(-SW'(r1_ff));
         o2_ff <= sat32(SW'(r2a_ff) - SW'(r2b_ff) + m2b_ff);
         o3_ff <= sat32(m3b_ff - SW'(r3a_ff) - SW'(r3b_ff));
         o4_ff <= total_weight;
      end
   end

   assign right_joint_torque = o0_ff;
   assign left_joint_torque  = o1_ff;
   assign roll_torque        = o2_ff;
   assign pitch_torque       = o3_ff;
   assign vertical_force     = o4_ff;

endmodule

// ----- hdl/tiltrotor_gravity_vector_top.sv -----
// ----------------------------------------------------------------------------
// Tilt-rotor gravity vector: top level
// Four CORDIC lanes feeding a pipelined gravity-torque datapath.
// ----------------------------------------------------------------------------
// channel | dir | word
// req     | in  | tdata: right_tilt, left_tilt, roll_angle, pitch_angle (15 b each)
// rsp     | out | tdata: right/left joint, roll, pitch torque, vertical force
// csr     | in  | write: index 0..7, data 32 b
//
// One word per cycle unless rsp stalls; registers: fold, one stage per
// rotation, rounding, four multiply stages, saturating output register.
// Synchronous active-high reset clears valid bits and CSRs (tilt cosine: 16384).
// A stalled result freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tiltrotor_gravity_vector_top_defines.svh"

module tiltrotor_gravity_vector_top
   import tgv_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // right_tilt, left_tilt, roll_angle, pitch_angle, 4'b0
   input  logic [63:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // right_joint_torque, left_joint_torque, roll_torque, pitch_torque,
   // vertical_force
   output logic [159:0]          rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   localparam int NS  = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
   localparam int LAT = NS + 7;

   logic                     adv;
   logic                     vld_ff [LAT];
   logic signed [REG_W-1:0]  k2_ff, k3_ff, mx_ff, my_ff, mz_ff, tw_ff;
   logic signed [TILT_W-1:0] sb_ff, cb_ff;
   logic signed [QW-1:0]     s_ar, c_ar, s_al, c_al, s_p, c_p, s_t, c_t;
   logic [RES_W-1:0]         o0, o1, o2, o3, o4;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k2_ff <= '0;
         k3_ff <= '0;
         sb_ff <= '0;
         cb_ff <= 16'sd16384;
         mx_ff <= '0;
         my_ff <= '0;
         mz_ff <= '0;
         tw_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_RIGHT_ARM_WEIGHT: k2_ff <= csr_wdata;
            CSR_LEFT_ARM_WEIGHT:  k3_ff <= csr_wdata;
            CSR_TILT_SINE:        sb_ff <= csr_wdata[TILT_W-1:0];
            CSR_TILT_COSINE:      cb_ff <= csr_wdata[TILT_W-1:0];
            CSR_MOMENT_X:         mx_ff <= csr_wdata;
            CSR_MOMENT_Y:         my_ff <= csr_wdata;
            CSR_MOMENT_Z:         mz_ff <= csr_wdata;
            CSR_TOTAL_WEIGHT:     tw_ff <= csr_wdata;
            default:              tw_ff <= tw_ff;
         endcase
      end
   end

   tgv_cordic #(.STEPS(STEPS)) u_cordic_ar (
      .clock(clock), .adv(adv), .angle(req_tdata[14:0]),
      .sin_q16(s_ar), .cos_q16(c_ar)
   );

   tgv_cordic #(.STEPS(STEPS)) u_cordic_al (
      .clock(clock), .adv(adv), .angle(req_tdata[29:15]),
      .sin_q16(s_al), .cos_q16(c_al)
   );

   tgv_cordic #(.STEPS(STEPS)) u_cordic_p (
      .clock(clock), .adv(adv), .angle(req_tdata[44:30]),
      .sin_q16(s_p), .cos_q16(c_p)
   );

   tgv_cordic #(.STEPS(STEPS)) u_cordic_t (
      .clock(clock), .adv(adv), .angle(req_tdata[59:45]),
      .sin_q16(s_t), .cos_q16(c_t)
   );

   tgv_gravity u_gravity (
      .clock(clock), .adv(adv),
      .s_ar(s_ar), .c_ar(c_ar), .s_al(s_al), .c_al(c_al),
      .s_p(s_p), .c_p(c_p), .s_t(s_t), .c_t(c_t),
      .k2(k2_ff), .k3(k3_ff), .tilt_sine(sb_ff), .tilt_cosine(cb_ff),
      .moment_x(mx_ff), .moment_y(my_ff), .moment_z(mz_ff), .total_weight(tw_ff),
      .right_joint_torque(o0), .left_joint_torque(o1), .roll_torque(o2),
      .pitch_torque(o3), .vertical_force(o4)
   );

   assign rsp_tdata = {o4, o3, o2, o1, o0};

   `TGV_ASSERT_NOW(a_stall_back, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "stall not propagated to input")
   `TGV_ASSERT_NOW(a_force_reg, clock, reset, rsp_tvalid && $stable(tw_ff) && $past(!csr_wen), rsp_tdata[159:128] == tw_ff, "vertical force differs from total weight")
   `TGV_ASSERT_NEXT(a_hold_pipe, clock, reset, !adv, rsp_tvalid, "pipeline frozen without a waiting result")

endmodule
